>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Both macros expect signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/tte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    // Screen geometry in character cells.
    localparam int COLUMNS = 64;
    localparam int ROWS    = 32;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the output channel.
    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_ERASE  = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;

    // Reset value of the tab width register.
    localparam logic [3:0] TAB_WIDTH_RESET = 4'd4;

    // All commands caused by one character, in emission order:
    // erase, draw, scroll. Erase and draw share the display row.
    typedef struct packed {
        logic       erase_valid;
        logic [6:0] erase_column;
        logic [6:0] erase_end;
        logic       draw_valid;
        logic [7:0] glyph;
        logic [6:0] draw_column;
        logic [4:0] row;
        logic       scroll_valid;
        logic [4:0] scroll_row;
        logic [5:0] scroll_line;
    } bundle_t;

endpackage

`default_nettype wire

>>> rtl/core/tte_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tte_front #(
    parameter int COLUMNS = tte_pkg::COLUMNS,
    parameter int ROWS    = tte_pkg::ROWS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [3:0]       cfg_wdata,
    input  wire logic             char_valid,
    input  wire logic [7:0]       char_code,
    input  wire logic             queue_full,
    output tte_pkg::bundle_t      push_data,
    output logic                  push
);

    // Parser states.
    localparam logic [2:0] PS_NORMAL  = 3'd0;
    localparam logic [2:0] PS_ESC     = 3'd1;
    localparam logic [2:0] PS_BRACKET = 3'd2;
    localparam logic [2:0] PS_FIRST   = 3'd3;
    localparam logic [2:0] PS_SECOND  = 3'd4;

    // Character codes the engine reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_LBRKT = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;

    localparam logic [6:0] COLS_LIM = 7'(COLUMNS);
    localparam logic [5:0] ROWS_LIM = 6'(ROWS);

    logic [3:0] tab_width_reg;
    logic [2:0] ps_reg, ps_next;
    logic [7:0] esc_reg, esc_next;
    logic [6:0] cur_reg, cur_next;
    logic [6:0] mark_reg, mark_next;
    logic [5:0] lrow_reg, lrow_next;
    logic [4:0] drow_reg, drow_next;
    logic [5:0] sp_reg, sp_next;
    logic [7:0] prev_reg, prev_next;

    logic             accept;
    logic             digit;
    logic [3:0]       digit_val;
    logic [11:0]      esc_mul;
    logic             used;
    logic             run_cmd;
    logic             new_line;
    logic [6:0]       step_col;
    logic [6:0]       tab_mark;
    logic [7:0]       dn;
    logic [5:0]       lrow_inc;
    logic [5:0]       sp_inc;
    logic [5:0]       sp_new;
    tte_pkg::bundle_t bnd;

    assign accept    = char_valid && !queue_full;
    assign digit     = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign digit_val = char_code[3:0];
    assign esc_mul   = {1'b0, esc_reg, 3'b000} + {3'b000, esc_reg, 1'b0}
                     + {8'd0, digit_val};

    // Parser and cursor update for one character.
    always_comb
    begin
        ps_next   = ps_reg;
        esc_next  = esc_reg;
        cur_next  = cur_reg;
        mark_next = mark_reg;
        lrow_next = lrow_reg;
        drow_next = drow_reg;
        sp_next   = sp_reg;
        prev_next = prev_reg;
        used      = 1'b0;
        run_cmd   = 1'b0;
        new_line  = 1'b0;
        step_col  = 7'd0;
        tab_mark  = 7'd0;
        dn        = 8'd0;
        lrow_inc  = 6'd0;
        sp_inc    = 6'd0;
        sp_new    = 6'd0;
        bnd       = '0;
        bnd.row   = drow_reg;

        // Escape sequence parsing.
        unique case (ps_reg)
            PS_ESC:
            begin
                if (char_code == CH_LBRKT)
                begin
                    ps_next  = PS_BRACKET;
                    esc_next = 8'd0;
                    used     = 1'b1;
                end
                else
                begin
                    ps_next = PS_NORMAL;
                end
            end
            PS_BRACKET:
            begin
                if (digit)
                begin
                    ps_next  = PS_FIRST;
                    esc_next = {4'd0, digit_val};
                    used     = 1'b1;
                end
                else
                begin
                    run_cmd = 1'b1;
                end
            end
            PS_FIRST:
            begin
                if (digit)
                begin
                    esc_next = (esc_mul > 12'd255) ? 8'd255 : esc_mul[7:0];
                    used     = 1'b1;
                end
                else if (char_code == CH_SEMI)
                begin
                    ps_next = PS_SECOND;
                    used    = 1'b1;
                end
                else
                begin
                    run_cmd = 1'b1;
                end
            end
            PS_SECOND:
            begin
                if (digit)
                begin
                    used = 1'b1;
                end
                else
                begin
                    run_cmd = 1'b1;
                end
            end
            default:
            begin
                ps_next = PS_NORMAL;
            end
        endcase

        // Command letter at the end of a sequence.
        if (run_cmd)
        begin
            ps_next = PS_NORMAL;
            if (char_code == CH_K)
            begin
                bnd.erase_valid  = 1'b1;
                bnd.erase_column = cur_reg;
                bnd.erase_end    = mark_reg;
                mark_next        = cur_reg;
                used             = 1'b1;
            end
            else if (char_code == CH_D)
            begin
                dn = (esc_reg == 8'd0) ? 8'd1 : esc_reg;
                if (dn > {1'b0, cur_reg})
                begin
                    dn = {1'b0, cur_reg};
                end
                esc_next = dn;
                cur_next = cur_reg - dn[6:0];
                used     = 1'b1;
            end
            else if (char_code == CH_M)
            begin
                used = 1'b1;
            end
        end

        // Ordinary character handling.
        if (!used && (char_code != CH_NUL))
        begin
            prev_next = char_code;
            unique case (char_code)
                CH_LF:
                begin
                    new_line = (prev_reg != CH_CR);
                end
                CH_CR:
                begin
                    new_line = 1'b1;
                end
                CH_TAB:
                begin
                    step_col  = cur_reg + {3'd0, tab_width_reg};
                    tab_mark  = (step_col > mark_reg) ? step_col : mark_reg;
                    cur_next  = step_col;
                    mark_next = tab_mark;
                    new_line  = (tab_mark >= COLS_LIM);
                end
                CH_BS:
                begin
                    if (cur_reg != 7'd0)
                    begin
                        cur_next = cur_reg - 7'd1;
                    end
                end
                CH_ESC:
                begin
                    ps_next = PS_ESC;
                end
                default:
                begin
                    // Printable: stale text right of the cursor goes first.
                    if (cur_reg < mark_reg)
                    begin
                        bnd.erase_valid  = 1'b1;
                        bnd.erase_column = cur_reg;
                        bnd.erase_end    = mark_reg;
                    end
                    bnd.draw_valid  = 1'b1;
                    bnd.glyph       = char_code;
                    bnd.draw_column = cur_reg;
                    step_col        = cur_reg + 7'd1;
                    cur_next        = step_col;
                    mark_next       = step_col;
                    new_line        = (step_col >= COLS_LIM);
                end
            endcase
        end

        // New line, with a scroll once the screen is full.
        if (new_line)
        begin
            lrow_inc = lrow_reg + 6'd1;
            if (lrow_inc >= ROWS_LIM)
            begin
                sp_inc  = sp_reg + 6'd1;
                sp_new  = ((sp_inc > ROWS_LIM) || (sp_inc == 6'd0)) ? 6'd1 : sp_inc;
                lrow_next        = ROWS_LIM;
                sp_next          = sp_new;
                drow_next        = 5'(sp_new - 6'd1);
                bnd.scroll_valid = 1'b1;
                bnd.scroll_row   = 5'(sp_new - 6'd1);
                bnd.scroll_line  = sp_new;
            end
            else
            begin
                lrow_next = lrow_inc;
                drow_next = lrow_inc[4:0];
            end
            cur_next  = 7'd0;
            mark_next = 7'd0;
        end
    end

    assign push_data = bnd;
    assign push      = accept && (bnd.erase_valid || bnd.draw_valid || bnd.scroll_valid);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= tte_pkg::TAB_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            tab_width_reg <= cfg_wdata;
        end
    end

    // Terminal state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg   <= PS_NORMAL;
            esc_reg  <= 8'd0;
            cur_reg  <= 7'd0;
            mark_reg <= 7'd0;
            lrow_reg <= 6'd0;
            drow_reg <= 5'd0;
            sp_reg   <= 6'd0;
            prev_reg <= 8'd0;
        end
        else if (accept)
        begin
            ps_reg   <= ps_next;
            esc_reg  <= esc_next;
            cur_reg  <= cur_next;
            mark_reg <= mark_next;
            lrow_reg <= lrow_next;
            drow_reg <= drow_next;
            sp_reg   <= sp_next;
            prev_reg <= prev_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tte_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tte_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire tte_pkg::bundle_t push_data,
    input  wire logic             pop,
    output tte_pkg::bundle_t      head,
    output logic                  head_valid,
    output logic                  full
);

    localparam int DEPTH = tte_pkg::QUEUE_DEPTH;

    tte_pkg::bundle_t                  entry_reg [DEPTH];
    logic [tte_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [tte_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [tte_pkg::QCNT_W-1:0]        count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == tte_pkg::QCNT_W'(DEPTH));

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tte_pkg::QPTR_W'(DEPTH - 1)) ? '0
                        : wr_ptr_reg + tte_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tte_pkg::QPTR_W'(DEPTH - 1)) ? '0
                        : rd_ptr_reg + tte_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + tte_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tte_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tte_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tte_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tte_pkg::bundle_t head,
    input  wire logic             head_valid,
    output logic                  pop,
    output logic                  cmd_valid,
    input  wire logic             cmd_stall,
    output logic [1:0]            command,
    output logic [7:0]            glyph,
    output logic [6:0]            column,
    output logic [6:0]            end_column,
    output logic [4:0]            row,
    output logic [5:0]            scroll_line,
    output logic                  last
);

    // Bit order of the pending mask: erase, draw, scroll.
    localparam int P_ERASE  = 0;
    localparam int P_DRAW   = 1;
    localparam int P_SCROLL = 2;

    logic [2:0] done_reg, done_next;
    logic       valid_reg, valid_next;
    logic [1:0] command_reg;
    logic [7:0] glyph_reg;
    logic [6:0] column_reg;
    logic [6:0] end_column_reg;
    logic [4:0] row_reg;
    logic [5:0] scroll_line_reg;
    logic       last_reg;

    logic [2:0] pending;
    logic [2:0] sel;
    logic       load;
    logic       sel_last;
    logic [1:0] sel_command;
    logic [7:0] sel_glyph;
    logic [6:0] sel_column;
    logic [6:0] sel_end;
    logic [4:0] sel_row;
    logic [5:0] sel_line;

    assign pending = {head.scroll_valid, head.draw_valid, head.erase_valid} & ~done_reg;
    assign load    = head_valid && (!valid_reg || !cmd_stall);

    // Pick the earliest command of the head request still to be sent.
    always_comb
    begin
        sel         = 3'b000;
        sel_command = tte_pkg::CMD_DRAW;
        sel_glyph   = 8'd0;
        sel_column  = 7'd0;
        sel_end     = 7'd0;
        sel_row     = head.row;
        sel_line    = 6'd0;
        priority if (pending[P_ERASE])
        begin
            sel[P_ERASE] = 1'b1;
            sel_command  = tte_pkg::CMD_ERASE;
            sel_column   = head.erase_column;
            sel_end      = head.erase_end;
        end
        else if (pending[P_DRAW])
        begin
            sel[P_DRAW] = 1'b1;
            sel_command = tte_pkg::CMD_DRAW;
            sel_glyph   = head.glyph;
            sel_column  = head.draw_column;
        end
        else
        begin
            sel[P_SCROLL] = 1'b1;
            sel_command   = tte_pkg::CMD_SCROLL;
            sel_row       = head.scroll_row;
            sel_line      = head.scroll_line;
        end
    end

    assign sel_last = ((pending & ~sel) == 3'b000);
    assign pop      = load && sel_last;

    // Progress through the head request and output valid.
    always_comb
    begin
        done_next  = done_reg;
        valid_next = valid_reg;
        if (load)
        begin
            done_next  = sel_last ? 3'b000 : (done_reg | sel);
            valid_next = 1'b1;
        end
        else if (!cmd_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 3'b000;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            command_reg     <= sel_command;
            glyph_reg       <= sel_glyph;
            column_reg      <= sel_column;
            end_column_reg  <= sel_end;
            row_reg         <= sel_row;
            scroll_line_reg <= sel_line;
            last_reg        <= sel_last;
        end
    end

    assign cmd_valid   = valid_reg;
    assign command     = command_reg;
    assign glyph       = glyph_reg;
    assign column      = column_reg;
    assign end_column  = end_column_reg;
    assign row         = row_reg;
    assign scroll_line = scroll_line_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

>>> rtl/core/text_terminal_char_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Character engine of a scrolling text terminal.
// Input channel: char_valid / char_stall carry one character byte per request
// on char_code. Output channel: cmd_valid / cmd_stall carry one drawing
// command per request (draw, erase to end mark, or scroll and clear row);
// last marks the final command that a character causes.
// Configuration: tab_width is written through cfg_we / cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// The first command of a character passes the request queue and then the
// output register. A character causes one to three commands, zero for bytes
// that only move the cursor or feed the parser. Throughput: the front accepts
// a character every cycle while the two-entry request queue has room; the back
// drains it through the output register one command per cycle unless stalled.
// Reset clears the cursor, rows, scroll line, parser and queue, and sets the
// tab width to four.
// When the receiver stalls, the current command holds; the queue then fills
// and char_stall rises.
module text_terminal_char_engine #(
    parameter int COLUMNS = tte_pkg::COLUMNS,
    parameter int ROWS    = tte_pkg::ROWS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire logic [7:0] char_code,
    output logic            cmd_valid,
    input  wire logic       cmd_stall,
    output logic [1:0]      command,
    output logic [7:0]      glyph,
    output logic [6:0]      column,
    output logic [6:0]      end_column,
    output logic [4:0]      row,
    output logic [5:0]      scroll_line,
    output logic            last
);

    tte_pkg::bundle_t push_data;
    tte_pkg::bundle_t head;
    logic             push;
    logic             pop;
    logic             head_valid;
    logic             queue_full;

    assign char_stall = queue_full;

    tte_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .char_valid (char_valid),
        .char_code  (char_code),
        .queue_full (queue_full),
        .push_data  (push_data),
        .push       (push)
    );

    tte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    tte_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .glyph       (glyph),
        .column      (column),
        .end_column  (end_column),
        .row         (row),
        .scroll_line (scroll_line),
        .last        (last)
    );

endmodule

`default_nettype wire

>>> rtl/core/tte_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tte_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire logic       cmd_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] glyph,
    input  wire logic [6:0] column,
    input  wire logic [6:0] end_column,
    input  wire logic [4:0] row,
    input  wire logic [5:0] scroll_line,
    input  wire logic       last
);

    logic [35:0] payload;
    logic        is_draw;
    logic        is_erase;
    logic        is_scroll;
    logic [4:0]  scroll_row;

    assign payload    = {command, glyph, column, end_column, row, scroll_line, last};
    assign is_draw    = cmd_valid && (command == tte_pkg::CMD_DRAW);
    assign is_erase   = cmd_valid && (command == tte_pkg::CMD_ERASE);
    assign is_scroll  = cmd_valid && (command == tte_pkg::CMD_SCROLL);
    assign scroll_row = 5'(scroll_line - 6'd1);

    // A stalled command stays in place.
    `ASSERT_NEXT(a_out_hold, cmd_valid && cmd_stall, cmd_valid && $stable(payload))

    // A draw carries no erase end and no scroll line.
    `ASSERT_IMPL(a_draw_clean, is_draw, (end_column == 7'd0) && (scroll_line == 6'd0))

    // A scroll clears the row just above the new scroll line.
    `ASSERT_IMPL(a_scroll_row, is_scroll, (scroll_line != 6'd0) && (row == scroll_row))

    // A scroll is always the final command of its character.
    `ASSERT_IMPL(a_scroll_last, is_scroll, last)

    // An erase carries no glyph and no scroll line.
    `ASSERT_IMPL(a_erase_clean, is_erase, (glyph == 8'd0) && (scroll_line == 6'd0))

endmodule

bind text_terminal_char_engine tte_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .command     (command),
    .glyph       (glyph),
    .column      (column),
    .end_column  (end_column),
    .row         (row),
    .scroll_line (scroll_line),
    .last        (last)
);

`default_nettype wire
